// ===== hdl/ubpt_pkg.sv =====
// ----------------------------------------------------------------------------
// ubpt_pkg
// Shared types and constants for the uniform bucket placement table.
// ----------------------------------------------------------------------------
package ubpt_pkg;

  // default table geometry
  localparam int unsigned MAX_CHILDREN_DEF = 16;
  localparam int unsigned LABEL_BITS_DEF   = 32;

  // fixed field widths of the stream beats
  localparam int unsigned IN_TDATA_W   = 120;
  localparam int unsigned IN_TUSER_W   = 2;
  localparam int unsigned OUT_TDATA_W  = 40;
  localparam int unsigned OUT_TUSER_W  = 3;
  localparam int unsigned STRIDE_W     = 32;
  localparam int unsigned HASH_W       = 64;
  localparam int unsigned SUM_W        = 9;
  localparam int unsigned PROD_W       = SUM_W + STRIDE_W;
  localparam int unsigned DIV_CNT_W    = 6;

  // request kinds
  typedef enum logic [1:0] {
    REQ_SELECT = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_NS      = 3'd1,
    STAT_EMPTY   = 3'd2,
    STAT_DUP     = 3'd3,
    STAT_MISSING = 3'd4,
    STAT_FULL    = 3'd5
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_SEL_RD,
    ST_SEL_WAIT,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_APPEND,
    ST_DONE
  } state_e;

endpackage

// ===== hdl/ubpt_ram.sv =====
// ----------------------------------------------------------------------------
// ubpt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ubpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/uniform_bucket_placement_table.sv =====
// ----------------------------------------------------------------------------
// uniform_bucket_placement_table
// Ordered table of child labels with add, remove and hashed select requests.
// ----------------------------------------------------------------------------
//
//  channel  | direction | beat contents
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | request: tuser req_type, tdata hash/rank/... label
//  m_axis   | out       | result: tuser status, tdata chosen_id/chosen_index
//  cfg      | in        | hop_stride write, always ready
//
//  Select runs a multiply, an add, the bit-serial remainder unit, a table read
//  and then posts; a select with namespace_ok clear or an empty table posts
//  directly. Add and remove walk the table one entry at a time over the single
//  RAM read port, and remove then shifts later entries down one by one.
//  Input is taken only when the sequencer is idle.
//  Reset empties the table at once (entry count to zero); stride resets to 1.
//  A result held by a stalled m_axis does not block the next accept.
// ----------------------------------------------------------------------------
module uniform_bucket_placement_table #(
  parameter int unsigned MAX_CHILDREN = ubpt_pkg::MAX_CHILDREN_DEF,
  parameter int unsigned LABEL_BITS   = ubpt_pkg::LABEL_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [63:0] key_hash, [71:64] rank, [79:72] failure_count, [80] namespace_ok,
  // [112:81] child_id, [119:113] zero
  input  logic [ubpt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] req_type
  input  logic [ubpt_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] chosen_id, [35:32] chosen_index, [39:36] zero
  output logic [ubpt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [2:0] status
  output logic [ubpt_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  // configuration write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ubpt_pkg::STRIDE_W-1:0]      cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_CHILDREN + 1);
  localparam int unsigned AW = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;

  // input field views
  logic [63:0]           in_key;
  logic [7:0]            in_rank;
  logic [7:0]            in_fail;
  logic                  in_ns;
  logic [31:0]           in_child;
  ubpt_pkg::req_e        in_req;
  logic                  in_acc;

  assign in_key   = s_axis_tdata[63:0];
  assign in_rank  = s_axis_tdata[71:64];
  assign in_fail  = s_axis_tdata[79:72];
  assign in_ns    = s_axis_tdata[80];
  assign in_child = s_axis_tdata[112:81];
  assign in_req   = ubpt_pkg::req_e'(s_axis_tuser[1:0]);
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // state and registers
  ubpt_pkg::state_e             state_q, state_d;
  ubpt_pkg::req_e               req_q, req_d;
  logic [63:0]                  key_q, key_d;
  logic [ubpt_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [LABEL_BITS-1:0]        lbl_q, lbl_d;
  logic [ubpt_pkg::STRIDE_W-1:0] stride_q;
  logic [ubpt_pkg::PROD_W-1:0]  prod_q, prod_d;
  logic [63:0]                  h_q, h_d;
  logic [CW-1:0]                rem_q, rem_d;
  logic [ubpt_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CW-1:0]                idx_q, idx_d;
  logic [CW-1:0]                total_q, total_d;
  ubpt_pkg::status_e            res_status_q, res_status_d;
  logic [31:0]                  res_id_q, res_id_d;
  logic [3:0]                   res_index_q, res_index_d;
  logic                         m_valid_q, m_valid_d;
  ubpt_pkg::status_e            out_status_q, out_status_d;
  logic [31:0]                  out_id_q, out_id_d;
  logic [3:0]                   out_index_q, out_index_d;

  // table RAM
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [LABEL_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [LABEL_BITS-1:0] ram_rdata;

  ubpt_ram #(
    .WIDTH (LABEL_BITS),
    .DEPTH (MAX_CHILDREN)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared conditions
  logic [CW-1:0] idx_inc;
  logic          idx_last;
  logic          lbl_match;
  logic          tbl_empty;
  logic          tbl_full;
  logic          out_free;
  logic [CW:0]   div_trial;
  logic [CW:0]   div_diff;
  logic          div_ge;
  logic [63:0]   rdata_wide;
  logic [31:0]   rem_wide;

  assign idx_inc    = idx_q + 1'b1;
  assign idx_last   = (idx_inc == total_q);
  assign lbl_match  = (ram_rdata == lbl_q);
  assign tbl_empty  = (total_q == '0);
  assign tbl_full   = (total_q == CW'(MAX_CHILDREN));
  assign out_free   = !m_valid_q || m_axis_tready;
  assign div_trial  = {rem_q, h_q[63]};
  assign div_diff   = div_trial - {1'b0, total_q};
  assign div_ge     = (div_trial >= {1'b0, total_q});
  assign rdata_wide = 64'(ram_rdata);
  assign rem_wide   = 32'(rem_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ubpt_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_req)
            ubpt_pkg::REQ_SELECT: begin
              state_d = (!in_ns || tbl_empty) ? ubpt_pkg::ST_DONE : ubpt_pkg::ST_MUL;
            end
            ubpt_pkg::REQ_ADD: begin
              state_d = tbl_empty ? ubpt_pkg::ST_APPEND : ubpt_pkg::ST_SRCH_RD;
            end
            ubpt_pkg::REQ_REMOVE: begin
              state_d = tbl_empty ? ubpt_pkg::ST_DONE : ubpt_pkg::ST_SRCH_RD;
            end
            default: begin
              state_d = ubpt_pkg::ST_DONE;
            end
          endcase
        end
      end
      ubpt_pkg::ST_MUL:      state_d = ubpt_pkg::ST_ADD;
      ubpt_pkg::ST_ADD:      state_d = ubpt_pkg::ST_DIV;
      ubpt_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ubpt_pkg::ST_SEL_RD;
        end
      end
      ubpt_pkg::ST_SEL_RD:   state_d = ubpt_pkg::ST_SEL_WAIT;
      ubpt_pkg::ST_SEL_WAIT: state_d = ubpt_pkg::ST_DONE;
      ubpt_pkg::ST_SRCH_RD:  state_d = ubpt_pkg::ST_SRCH_CMP;
      ubpt_pkg::ST_SRCH_CMP: begin
        if (lbl_match) begin
          state_d = (req_q == ubpt_pkg::REQ_ADD) ? ubpt_pkg::ST_DONE : ubpt_pkg::ST_SHIFT_RD;
        end else if (idx_last) begin
          if (req_q == ubpt_pkg::REQ_ADD && !tbl_full) begin
            state_d = ubpt_pkg::ST_APPEND;
          end else begin
            state_d = ubpt_pkg::ST_DONE;
          end
        end else begin
          state_d = ubpt_pkg::ST_SRCH_RD;
        end
      end
      ubpt_pkg::ST_SHIFT_RD: begin
        state_d = idx_last ? ubpt_pkg::ST_DONE : ubpt_pkg::ST_SHIFT_WR;
      end
      ubpt_pkg::ST_SHIFT_WR: state_d = ubpt_pkg::ST_SHIFT_RD;
      ubpt_pkg::ST_APPEND:   state_d = ubpt_pkg::ST_DONE;
      ubpt_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = ubpt_pkg::ST_IDLE;
        end
      end
      default: state_d = ubpt_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    req_d        = req_q;
    key_d        = key_q;
    sum_d        = sum_q;
    lbl_d        = lbl_q;
    prod_d       = prod_q;
    h_d          = h_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    total_d      = total_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_index_d  = res_index_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_index_d  = out_index_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = idx_q[AW-1:0];
    case (state_q)
      ubpt_pkg::ST_IDLE: begin
        // capture the request and preset the result
        if (in_acc) begin
          req_d        = in_req;
          key_d        = in_key;
          sum_d        = ubpt_pkg::SUM_W'(in_rank) + ubpt_pkg::SUM_W'(in_fail);
          lbl_d        = LABEL_BITS'(in_child);
          rem_d        = '0;
          cnt_d        = '1;
          idx_d        = '0;
          res_status_d = ubpt_pkg::STAT_OK;
          res_id_d     = '0;
          res_index_d  = '0;
          if (in_req == ubpt_pkg::REQ_SELECT) begin
            if (!in_ns) begin
              res_status_d = ubpt_pkg::STAT_NS;
            end else if (tbl_empty) begin
              res_status_d = ubpt_pkg::STAT_EMPTY;
            end
          end else if (in_req == ubpt_pkg::REQ_REMOVE && tbl_empty) begin
            res_status_d = ubpt_pkg::STAT_MISSING;
          end
        end
      end
      ubpt_pkg::ST_MUL: begin
        prod_d = ubpt_pkg::PROD_W'(sum_q) * ubpt_pkg::PROD_W'(stride_q);
      end
      ubpt_pkg::ST_ADD: begin
        h_d = key_q + 64'(prod_q);
      end
      ubpt_pkg::ST_DIV: begin
        // one restoring remainder step per cycle, MSB first
        rem_d = div_ge ? div_diff[CW-1:0] : div_trial[CW-1:0];
        h_d   = {h_q[62:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
      end
      ubpt_pkg::ST_SEL_RD: begin
        ram_raddr = rem_q[AW-1:0];
      end
      ubpt_pkg::ST_SEL_WAIT: begin
        res_id_d    = rdata_wide[31:0];
        res_index_d = rem_wide[3:0];
      end
      ubpt_pkg::ST_SRCH_RD: begin
        ram_raddr = idx_q[AW-1:0];
      end
      ubpt_pkg::ST_SRCH_CMP: begin
        // compare one entry, advance or settle the outcome
        if (lbl_match) begin
          if (req_q == ubpt_pkg::REQ_ADD) begin
            res_status_d = ubpt_pkg::STAT_DUP;
          end
        end else if (idx_last) begin
          if (req_q == ubpt_pkg::REQ_ADD) begin
            if (tbl_full) begin
              res_status_d = ubpt_pkg::STAT_FULL;
            end
          end else begin
            res_status_d = ubpt_pkg::STAT_MISSING;
          end
        end else begin
          idx_d = idx_inc;
        end
      end
      ubpt_pkg::ST_SHIFT_RD: begin
        // fetch the next entry, or drop the last slot when done
        ram_raddr = idx_inc[AW-1:0];
        if (idx_last) begin
          total_d = total_q - 1'b1;
        end
      end
      ubpt_pkg::ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = ram_rdata;
        idx_d     = idx_inc;
      end
      ubpt_pkg::ST_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = total_q[AW-1:0];
        ram_wdata = lbl_q;
        total_d   = total_q + 1'b1;
      end
      ubpt_pkg::ST_DONE: begin
        // post the result once the output register is free
        if (out_free) begin
          m_valid_d    = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = res_id_q;
          out_index_d  = res_index_q;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ubpt_pkg::ST_IDLE;
      total_q   <= '0;
      m_valid_q <= 1'b0;
      stride_q  <= ubpt_pkg::STRIDE_W'(1);
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        stride_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    key_q        <= key_d;
    sum_q        <= sum_d;
    lbl_q        <= lbl_d;
    prod_q       <= prod_d;
    h_q          <= h_d;
    rem_q        <= rem_d;
    cnt_q        <= cnt_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_index_q  <= res_index_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_index_q  <= out_index_d;
  end

  // ports
  assign s_axis_tready = (state_q == ubpt_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, out_index_q, out_id_q};
  assign m_axis_tuser  = ubpt_pkg::OUT_TUSER_W'(out_status_q);

endmodule
